### src/tgf_pkg.sv
// Shared types, constants and defaults for the tone generator with fade.
`default_nettype none

package tgf_pkg;

    // Defaults for the top-level parameters.
    localparam int PHASE_BITS_DEF       = 24;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF      = 16;
    localparam int LENGTH_BITS_DEF      = 16;

    // Input transaction layout.
    localparam int STEP_W    = 23;
    localparam int NOTE_W    = 16;
    localparam int IN_DATA_W = 40;
    localparam int STEP_LSB  = 0;
    localparam int NOTE_LSB  = 23;
    localparam int SQ_BIT    = 39;

    // Request kinds carried on the input tuser.
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Shared multiplier and reciprocal widths.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int RECIP_W = 32;

    // Quarter-wave sine polynomial, Q16.
    localparam int          X_W   = 17;
    localparam logic [16:0] COEF1 = 17'd102939;
    localparam logic [16:0] COEF3 = 17'd42159;
    localparam logic [16:0] COEF5 = 17'd4765;
    localparam logic [16:0] Y_MAX = 17'd65536;
    localparam int          ROUND_HALF = 32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_X2,
        ST_T1,
        ST_T2,
        ST_Y,
        ST_AMP,
        ST_MAG,
        ST_GAIN,
        ST_FADE,
        ST_SCALE,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

### src/tone_generator_with_fade.sv
// Top level of the tone generator: sequencer, note state and output register.
// A tick goes straight to ST_OUT when no note runs, via ST_MAG (square) or ST_X2 to ST_MAG
// (sine) during a note, and also via ST_GAIN, ST_FADE and ST_SCALE inside the fade region.
// Requests are taken only in ST_IDLE, since all products share a single multiplier.
// A nonzero-length note start runs the 32-step reciprocal divider before the next request.
// Reset (synchronous, active low) leaves the block idle with sound enabled and no result.
`default_nettype none

module tone_generator_with_fade #(
    parameter int PHASE_BITS       = tgf_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = tgf_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS      = tgf_pkg::SAMPLE_BITS_DEF,
    parameter int LENGTH_BITS      = tgf_pkg::LENGTH_BITS_DEF,
    localparam int OUT_W           = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration: sound_enable.
    input  wire logic                          i_cfg_wr_en,
    input  wire logic                          i_cfg_wr_data,
    // Request stream.
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // Fields from bit 0 up: phase_step[22:0], note_length[38:23], square_wave[39].
    input  wire logic [tgf_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // Field: req_type.
    input  wire logic                          i_s_axis_tuser,
    // Sample stream.
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // Field from bit 0 up: sample, zero-padded to whole bytes.
    output logic      [OUT_W-1:0]              o_m_axis_tdata,
    // Field: last_sample.
    output logic                               o_m_axis_tlast,
    // Field: note_active.
    output logic                               o_m_axis_tuser
);

    // The sine table index is the top LG phase bits; the quarter wave has 2^QLG steps.
    localparam int LG    = $clog2(SINE_TABLE_DEPTH);
    localparam int QLG   = LG - 2;
    localparam int X_SHIFT = 16 - QLG;
    localparam logic [QLG:0] QSIZE = (QLG + 1)'(1 << QLG);

    // Amplitudes 0.12 and 0.08 of full scale, rounded.
    localparam logic [tgf_pkg::MUL_B_W-1:0] AMP_SINE =
        tgf_pkg::MUL_B_W'(((12 << (SAMPLE_BITS - 1)) + 50) / 100);
    localparam logic [SAMPLE_BITS-1:0] AMP_SQUARE =
        SAMPLE_BITS'(((8 << (SAMPLE_BITS - 1)) + 50) / 100);

    tgf_pkg::t_state r_state;
    tgf_pkg::t_state n_state;

    // Configuration and note state.
    logic                        r_enable;
    logic                        r_playing;
    logic [PHASE_BITS-1:0]       r_phase;
    logic [LENGTH_BITS-1:0]      r_idx;
    logic [LENGTH_BITS-1:0]      r_len;
    logic [tgf_pkg::STEP_W-1:0]  r_step;
    logic                        r_square;
    logic [tgf_pkg::RECIP_W-1:0] r_recip;

    // Per-sample working registers.
    logic                        r_active;
    logic [tgf_pkg::X_W-1:0]     r_x;
    logic [tgf_pkg::X_W-1:0]     r_x2;
    logic [SAMPLE_BITS-1:0]      r_mag;

    // Output register.
    logic                        r_out_valid;
    logic [SAMPLE_BITS-1:0]      r_out_data;
    logic                        r_out_last;
    logic                        r_out_active;

    // Input unpacking.
    logic                        w_in_accept;
    logic                        w_in_start;
    logic [tgf_pkg::STEP_W-1:0]  w_in_step;
    logic [LENGTH_BITS-1:0]      w_in_len;
    logic                        w_in_square;

    // Datapath.
    logic                        w_quad_odd;
    logic [QLG-1:0]              w_j;
    logic [QLG:0]                w_j_eff;
    logic [tgf_pkg::X_W-1:0]     w_x;
    logic                        w_neg;
    logic [tgf_pkg::MUL_P_W-1:0] w_prod;
    logic [tgf_pkg::MUL_P_W-1:0] w_round;
    logic [tgf_pkg::X_W-1:0]     w_prod_q;
    logic [tgf_pkg::X_W-1:0]     w_t1;
    logic [tgf_pkg::X_W-1:0]     w_t2;
    logic [tgf_pkg::X_W-1:0]     w_y;
    logic [LENGTH_BITS+2:0]      w_five_i;
    logic [LENGTH_BITS+2:0]      w_four_n;
    logic [LENGTH_BITS-1:0]      w_rem;
    logic [LENGTH_BITS+2:0]      w_five_rem;
    logic                        w_fade;
    logic                        w_last;
    logic                        w_end;
    logic [SAMPLE_BITS-1:0]      w_signed;
    logic                        w_out_free;

    // Sequencer outputs.
    logic [tgf_pkg::MUL_A_W-1:0] w_mul_a;
    logic [tgf_pkg::MUL_B_W-1:0] w_mul_b;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [tgf_pkg::RECIP_W-1:0] w_div_quo;

    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_start  = (i_s_axis_tuser == tgf_pkg::REQ_START);
    assign w_in_step   = i_s_axis_tdata[tgf_pkg::STEP_LSB +: tgf_pkg::STEP_W];
    assign w_in_len    = LENGTH_BITS'({16'd0, i_s_axis_tdata[tgf_pkg::NOTE_LSB +: tgf_pkg::NOTE_W]});
    assign w_in_square = i_s_axis_tdata[tgf_pkg::SQ_BIT];

    // Quarter-wave position: mirrored in the second and fourth quadrants, scaled to Q16.
    // The sign of both waveforms is the phase MSB.
    always_comb begin
        w_quad_odd = r_phase[PHASE_BITS-2];
        w_j        = r_phase[PHASE_BITS-3 -: QLG];
        w_j_eff    = w_quad_odd ? (QSIZE - {1'b0, w_j}) : {1'b0, w_j};
        w_x        = tgf_pkg::X_W'(w_j_eff) << X_SHIFT;
        w_neg      = r_phase[PHASE_BITS-1];
    end

    // Product slices for each step of the polynomial and the scaling.
    always_comb begin
        w_prod_q = w_prod[16 +: tgf_pkg::X_W];
        w_round  = w_prod + tgf_pkg::MUL_P_W'(tgf_pkg::ROUND_HALF);
        w_t1     = tgf_pkg::COEF3 - w_prod_q;
        w_t2     = tgf_pkg::COEF1 - w_prod_q;
        w_y      = (w_prod_q > tgf_pkg::Y_MAX) ? tgf_pkg::Y_MAX : w_prod_q;
    end

    // Fade region is where 5*i > 4*N; the remaining fraction 5*(N-i) is below N there,
    // so the gain stays under one in Q16.
    always_comb begin
        w_five_i   = ({3'b000, r_idx} << 2) + {3'b000, r_idx};
        w_four_n   = {1'b0, r_len, 2'b00};
        w_rem      = r_len - r_idx;
        w_five_rem = ({3'b000, w_rem} << 2) + {3'b000, w_rem};
        w_fade     = (w_five_i > w_four_n) && (r_idx < r_len);
        w_last     = (({1'b0, r_idx} + 1'b1) == {1'b0, r_len});
        w_end      = (({1'b0, r_idx} + 1'b1) >= {1'b0, r_len});
        w_signed   = w_neg ? ('0 - r_mag) : r_mag;
        w_out_free = !r_out_valid || i_m_axis_tready;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tgf_pkg::ST_IDLE: begin
                if (w_in_accept) begin
                    if (w_in_start) begin
                        if (r_enable && (w_in_len != '0)) begin
                            n_state = tgf_pkg::ST_DIV;
                        end
                    end else if (!r_enable || !r_playing) begin
                        n_state = tgf_pkg::ST_OUT;
                    end else if (r_square) begin
                        n_state = tgf_pkg::ST_MAG;
                    end else begin
                        n_state = tgf_pkg::ST_X2;
                    end
                end
            end
            tgf_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = tgf_pkg::ST_IDLE;
                end
            end
            tgf_pkg::ST_X2:    n_state = tgf_pkg::ST_T1;
            tgf_pkg::ST_T1:    n_state = tgf_pkg::ST_T2;
            tgf_pkg::ST_T2:    n_state = tgf_pkg::ST_Y;
            tgf_pkg::ST_Y:     n_state = tgf_pkg::ST_AMP;
            tgf_pkg::ST_AMP:   n_state = tgf_pkg::ST_MAG;
            tgf_pkg::ST_MAG: begin
                n_state = w_fade ? tgf_pkg::ST_GAIN : tgf_pkg::ST_OUT;
            end
            tgf_pkg::ST_GAIN:  n_state = tgf_pkg::ST_FADE;
            tgf_pkg::ST_FADE:  n_state = tgf_pkg::ST_SCALE;
            tgf_pkg::ST_SCALE: n_state = tgf_pkg::ST_OUT;
            tgf_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_state = tgf_pkg::ST_IDLE;
                end
            end
            default:           n_state = tgf_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, divider start and multiplier operands.
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_div_start     = 1'b0;
        w_mul_a         = '0;
        w_mul_b         = '0;
        case (r_state)
            tgf_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_div_start     = i_s_axis_tvalid && w_in_start && r_enable
                                  && (w_in_len != '0);
            end
            tgf_pkg::ST_X2: begin
                w_mul_a = tgf_pkg::MUL_A_W'(w_x);
                w_mul_b = tgf_pkg::MUL_B_W'(w_x);
            end
            tgf_pkg::ST_T1: begin
                w_mul_a = tgf_pkg::MUL_A_W'(w_prod_q);
                w_mul_b = tgf_pkg::MUL_B_W'(tgf_pkg::COEF5);
            end
            tgf_pkg::ST_T2: begin
                w_mul_a = tgf_pkg::MUL_A_W'(r_x2);
                w_mul_b = tgf_pkg::MUL_B_W'(w_t1);
            end
            tgf_pkg::ST_Y: begin
                w_mul_a = tgf_pkg::MUL_A_W'(r_x);
                w_mul_b = tgf_pkg::MUL_B_W'(w_t2);
            end
            tgf_pkg::ST_AMP: begin
                w_mul_a = tgf_pkg::MUL_A_W'(w_y);
                w_mul_b = AMP_SINE;
            end
            tgf_pkg::ST_GAIN: begin
                w_mul_a = r_recip;
                w_mul_b = tgf_pkg::MUL_B_W'(w_five_rem);
            end
            tgf_pkg::ST_FADE: begin
                w_mul_a = tgf_pkg::MUL_A_W'(r_mag);
                w_mul_b = tgf_pkg::MUL_B_W'(w_prod[31:16]);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tgf_pkg::ST_IDLE;
            r_enable    <= 1'b1;
            r_playing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if ((r_state == tgf_pkg::ST_IDLE) && w_in_accept) begin
                if (w_in_start) begin
                    if (r_enable) begin
                        r_playing <= (w_in_len != '0);
                    end
                end else if (!r_enable) begin
                    // A tick while disabled aborts the running note.
                    r_playing <= 1'b0;
                end
            end
            if ((r_state == tgf_pkg::ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
                if (r_active && w_end) begin
                    r_playing <= 1'b0;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Note parameters, working registers and the output payload.
    always_ff @(posedge i_clk) begin
        case (r_state)
            tgf_pkg::ST_IDLE: begin
                if (w_in_accept) begin
                    if (w_in_start) begin
                        if (r_enable) begin
                            r_phase  <= '0;
                            r_idx    <= '0;
                            r_len    <= w_in_len;
                            r_step   <= w_in_step;
                            r_square <= w_in_square;
                            r_recip  <= '0;
                        end
                    end else begin
                        r_active <= r_enable && r_playing;
                        r_mag    <= AMP_SQUARE;
                    end
                end
            end
            tgf_pkg::ST_DIV: begin
                if (w_div_done) begin
                    r_recip <= w_div_quo;
                end
            end
            tgf_pkg::ST_X2: begin
                r_x <= w_x;
            end
            tgf_pkg::ST_T1: begin
                r_x2 <= w_prod_q;
            end
            tgf_pkg::ST_MAG: begin
                if (!r_square) begin
                    r_mag <= w_round[16 +: SAMPLE_BITS];
                end
            end
            tgf_pkg::ST_SCALE: begin
                r_mag <= w_prod[16 +: SAMPLE_BITS];
            end
            tgf_pkg::ST_OUT: begin
                if (w_out_free) begin
                    r_out_data   <= r_active ? w_signed : '0;
                    r_out_last   <= r_active && w_last;
                    r_out_active <= r_active;
                    if (r_active) begin
                        r_phase <= r_phase + PHASE_BITS'({9'd0, r_step});
                        r_idx   <= r_idx + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    tgf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    tgf_div #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_divisor  (w_in_len),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_data);
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_active;

endmodule

`default_nettype wire

### src/tgf_mul.sv
// Shared unsigned multiplier with a registered product.
`default_nettype none

module tgf_mul (
    input  wire logic                        i_clk,
    input  wire logic [tgf_pkg::MUL_A_W-1:0] i_a,
    input  wire logic [tgf_pkg::MUL_B_W-1:0] i_b,
    output logic      [tgf_pkg::MUL_P_W-1:0] o_p
);

    logic [tgf_pkg::MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= tgf_pkg::MUL_P_W'(i_a) * tgf_pkg::MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

### src/tgf_div.sv
// Radix-2 restoring divider that forms the fade reciprocal (2^32-1)/N.
`default_nettype none

module tgf_div #(
    parameter int LENGTH_BITS = tgf_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [LENGTH_BITS-1:0]      i_divisor,
    output logic                             o_done,
    output logic      [tgf_pkg::RECIP_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(tgf_pkg::RECIP_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [LENGTH_BITS-1:0]      r_div;
    logic [LENGTH_BITS-1:0]      r_rem;
    logic [tgf_pkg::RECIP_W-1:0] r_quo;

    logic [LENGTH_BITS:0]        w_trial;
    logic                        w_fits;
    logic [LENGTH_BITS:0]        w_diff;

    // The dividend is all ones, so a one is shifted in at every step.
    always_comb begin
        w_trial = {r_rem, 1'b1};
        w_fits  = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_cnt <= CNT_W'(tgf_pkg::RECIP_W - 1);
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[LENGTH_BITS-1:0] : w_trial[LENGTH_BITS-1:0];
            r_quo <= {r_quo[tgf_pkg::RECIP_W-2:0], w_fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### src/tgf_checker.sv
// Port-level checks for the tone generator, bound to the top level.
`default_nettype none

module tgf_checker #(
    parameter int OUT_W = 16
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_s_axis_tready,
    input wire logic                          o_m_axis_tvalid,
    input wire logic                          i_m_axis_tready,
    input wire logic [OUT_W-1:0]              o_m_axis_tdata,
    input wire logic                          o_m_axis_tlast,
    input wire logic                          o_m_axis_tuser
);

    // A sample waiting on a stalled sink stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("sample dropped while stalled");

    // Samples outside a note are silent and never close a note.
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> (o_m_axis_tdata == '0) && !o_m_axis_tlast)
        else $error("nonzero sample outside a note");

    // A new sample is produced only while the request side is held off.
    a_busy_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("sample appeared while accepting requests");

    // Reset leaves no sample pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("sample pending after reset");

endmodule

bind tone_generator_with_fade tgf_checker #(.OUT_W(OUT_W)) u_tgf_checker (.*);

`default_nettype wire
